[src/assert_macros.svh]
// assertion macros for the rtl files
// no dependencies; pulled in with an include inside the module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in the same cycle implies consequence in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/wta_pkg.sv]
// shared types, widths and helpers for the wall texel address block
// no dependencies
package wta_pkg;

  localparam int FACE_W   = 2;
  localparam int COORD_W  = 16;
  localparam int SCR_W    = 16;
  localparam int ROW_W    = 12;
  localparam int SIZE_W   = 11;
  localparam int BPP_W    = 6;
  localparam int TILES_W  = 8;
  localparam int TEX_W    = 10;
  localparam int OFF_W    = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd1024;

  typedef enum logic [FACE_W-1:0] {
    FACE_NORTH = 2'd0,
    FACE_EAST  = 2'd1,
    FACE_WEST  = 2'd2,
    FACE_SOUTH = 2'd3
  } face_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH   = 3'd0,
    REG_TEX_HEIGHT  = 3'd1,
    REG_BPP         = 3'd2,
    REG_MAP_WIDTH   = 3'd3,
    REG_MAP_HEIGHT  = 3'd4
  } cfg_reg_e;

  // zero reads as one, anything past the largest texture as the largest
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_MAX) begin
      r = SIZE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[src/wall_texel_address.sv]
// wall texel address: pipelined texel column, row and byte offset per wall pixel
// depends on wta_pkg and assert_macros.svh
//
// usage
// - request channel: in_valid_i / in_stall_o with one wall pixel per request
//   (face, hit coordinates, slice rows, row within the slice)
// - result channel: out_valid_o / out_stall_i with texel_valid, texture_select,
//   texel_x, texel_y and byte_offset
// - config channel: cfg_valid_i / cfg_ready_o, cfg_index_i picks the register,
//   cfg_data_i the value; ready is always high, write only while idle
// - throughput one request per cycle while out_stall_i does not hold the pipe;
//   the 10-stage restoring divider for the texel row sets the depth, one
//   quotient bit per stage
// - the column uses two reciprocal multiplies by the tile size, each followed
//   by a back-multiply and a single correction step
// - reset empties every stage and loads the default texture and map sizes
// - a stalled result holds in the last stage; stages behind it keep moving
//   into empty slots, and in_stall_o rises only once all 15 stages are full
module wall_texel_address #(
  parameter int TILE_UNITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [wta_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wta_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [wta_pkg::FACE_W-1:0]       wall_face_i,
  input  logic [wta_pkg::COORD_W-1:0]      hit_x_world_i,
  input  logic [wta_pkg::COORD_W-1:0]      hit_y_world_i,
  input  logic signed [wta_pkg::SCR_W-1:0] wall_top_screen_i,
  input  logic signed [wta_pkg::SCR_W-1:0] wall_bottom_screen_i,
  input  logic signed [wta_pkg::SCR_W-1:0] wall_top_clipped_i,
  input  logic [wta_pkg::ROW_W-1:0]        row_in_slice_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             texel_valid_o,
  output logic [wta_pkg::FACE_W-1:0]       texture_select_o,
  output logic [wta_pkg::TEX_W-1:0]        texel_x_o,
  output logic [wta_pkg::TEX_W-1:0]        texel_y_o,
  output logic [wta_pkg::OFF_W-1:0]        byte_offset_o
);
  import wta_pkg::*;
  `include "assert_macros.svh"

  // tile size and derived widths
  localparam int TIW  = $clog2(TILE_UNITS + 1);        // holds the tile size itself
  localparam int MW   = $clog2(TILE_UNITS);            // holds coord mod tile size
  localparam int SC_W = TILES_W + TIW;                 // map size in world units
  localparam int V_W  = (SC_W > COORD_W) ? SC_W : COORD_W;
  localparam int D_W  = V_W + 1;                       // signed mirror distance
  localparam int PW   = MW + SIZE_W;                   // m * tex_width
  localparam int NUM_W = SIZE_W + SCR_W;               // tex_height * row position
  localparam int HS_W = SCR_W + 1;                     // wall height, signed
  localparam int S_W  = SCR_W + 2;                     // row position, signed
  localparam int TY_W = SIZE_W + TEX_W;
  localparam int XB_W = TEX_W + BPP_W;
  localparam int TYB_W = TY_W + BPP_W;

  localparam logic [TIW-1:0] TILE_C = TIW'(TILE_UNITS);
  // floor reciprocals: the estimate is low by at most one
  localparam logic [V_W-1:0] R_M = V_W'((1 << V_W) / TILE_UNITS);
  localparam logic [PW-1:0]  R_X = PW'((1 << PW) / TILE_UNITS);
  localparam logic [SC_W-1:0] SCALED_RST = SC_W'(32 * TILE_UNITS);

  // stage map
  localparam int ST_IN      = 0;   // face decode, mirror distance, height, row position
  localparam int ST_PREP    = 1;   // abs distance, row range check, numerator
  localparam int ST_RECIP_M = 2;   // quotient estimate of coord / tile
  localparam int ST_BACK_M  = 3;   // estimate times tile
  localparam int ST_MOD     = 4;   // corrected remainder
  localparam int ST_SCALE   = 5;   // remainder times tex width
  localparam int ST_RECIP_X = 6;
  localparam int ST_BACK_X  = 7;
  localparam int ST_X       = 8;   // texel column
  localparam int DIV_FIRST  = 2;
  localparam int DIV_STEPS  = TEX_W;
  localparam int ST_Y       = DIV_FIRST + DIV_STEPS - 1;
  localparam int ST_MUL_A   = ST_Y + 1;
  localparam int ST_MUL_B   = ST_Y + 2;
  localparam int ST_OUT     = ST_Y + 3;
  localparam int NS         = ST_OUT + 1;

  typedef struct packed {
    face_e                   face;
    logic signed [D_W-1:0]   d;
    logic signed [HS_W-1:0]  h;
    logic signed [S_W-1:0]   s;
    logic [V_W-1:0]          v;
    logic                    neg;
    logic                    y_ok;
    logic [V_W-1:0]          qm;
    logic [V_W-1:0]          qt;
    logic [MW-1:0]           m;
    logic                    bad;
    logic [PW-1:0]           p;
    logic [PW-1:0]           qx;
    logic [PW-1:0]           qxt;
    logic [TEX_W-1:0]        x;
    logic [SCR_W-1:0]        h16;
    logic [NUM_W-1:0]        rem;
    logic [TEX_W-1:0]        quo;
    logic [TY_W-1:0]         ty;
    logic [XB_W-1:0]         xb;
    logic [TYB_W-1:0]        tyb;
    logic                    tex_ok;
    logic [OFF_W-1:0]        off;
  } stage_t;

  // config registers, sizes kept already clamped and map sizes already scaled
  logic [SIZE_W-1:0] tw_q, th_q;
  logic [BPP_W-1:0]  bpp_q;
  logic [SC_W-1:0]   mw_scaled_q, mh_scaled_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q        <= 11'd64;
      th_q        <= 11'd64;
      bpp_q       <= 6'd32;
      mw_scaled_q <= SCALED_RST;
      mh_scaled_q <= SCALED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TEX_WIDTH:  tw_q  <= clamp_size(cfg_data_i[SIZE_W-1:0]);
        REG_TEX_HEIGHT: th_q  <= clamp_size(cfg_data_i[SIZE_W-1:0]);
        REG_BPP:        bpp_q <= cfg_data_i[BPP_W-1:0];
        REG_MAP_WIDTH:  mw_scaled_q <= SC_W'(cfg_data_i[TILES_W-1:0]) * SC_W'(TILE_C);
        REG_MAP_HEIGHT: mh_scaled_q <= SC_W'(cfg_data_i[TILES_W-1:0]) * SC_W'(TILE_C);
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // pipeline state
  stage_t          pipe_q [NS];
  stage_t          pipe_d [NS];
  logic [NS-1:0]   vld_q;
  logic [NS-1:0]   en;

  // a stage moves when it is empty or some later stage has a hole,
  // or when the result leaves
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = !out_stall_i || (((~vld_q) >> k) != '0);
    end
  end

  assign in_stall_o = !en[ST_IN];

  // request decode
  face_e              in_face;
  logic               in_mirror;
  logic [COORD_W-1:0] in_coord;
  logic [SC_W-1:0]    in_scaled;

  assign in_face   = face_e'(wall_face_i);
  assign in_mirror = (in_face == FACE_NORTH) || (in_face == FACE_EAST);
  assign in_coord  = ((in_face == FACE_NORTH) || (in_face == FACE_SOUTH)) ?
                     hit_x_world_i : hit_y_world_i;
  assign in_scaled = (in_face == FACE_NORTH) ? mw_scaled_q : mh_scaled_q;

  // column datapath products
  logic [2*V_W-1:0]    mod_prod;
  logic [V_W+TIW-1:0]  mod_back;
  logic [V_W-1:0]      mod_rem;
  logic [V_W-1:0]      m_raw;
  logic [2*PW-1:0]     x_prod;
  logic [PW+TIW-1:0]   x_back;
  logic [PW-1:0]       x_rem;

  assign mod_prod = (2*V_W)'(pipe_q[ST_RECIP_M-1].v) * (2*V_W)'(R_M);
  assign mod_back = (V_W+TIW)'(pipe_q[ST_BACK_M-1].qm) * (V_W+TIW)'(TILE_C);
  assign mod_rem  = pipe_q[ST_MOD-1].v - pipe_q[ST_MOD-1].qt;
  assign m_raw    = (mod_rem >= V_W'(TILE_C)) ? (mod_rem - V_W'(TILE_C)) : mod_rem;
  assign x_prod   = (2*PW)'(pipe_q[ST_RECIP_X-1].p) * (2*PW)'(R_X);
  assign x_back   = (PW+TIW)'(pipe_q[ST_BACK_X-1].qx) * (PW+TIW)'(TILE_C);
  assign x_rem    = pipe_q[ST_X-1].p - pipe_q[ST_X-1].qxt;

  always_comb begin
    logic [NUM_W-1:0] trial;
    logic             ge;

    // entry stage
    pipe_d[ST_IN]      = '0;
    pipe_d[ST_IN].face = in_face;
    pipe_d[ST_IN].d    = in_mirror ?
                         ($signed(D_W'(in_scaled)) - $signed(D_W'(in_coord))) :
                         $signed(D_W'(in_coord));
    pipe_d[ST_IN].h    = $signed({wall_bottom_screen_i[SCR_W-1], wall_bottom_screen_i})
                       - $signed({wall_top_screen_i[SCR_W-1], wall_top_screen_i});
    // row position counted from the unclipped top
    pipe_d[ST_IN].s    = $signed({{(S_W-ROW_W){1'b0}}, row_in_slice_i})
                       + $signed({{2{wall_top_clipped_i[SCR_W-1]}}, wall_top_clipped_i})
                       - $signed({{2{wall_top_screen_i[SCR_W-1]}}, wall_top_screen_i});

    for (int k = 1; k < NS; k++) begin
      pipe_d[k] = pipe_q[k-1];
    end

    // row in range exactly when 0 <= s < h, so the quotient fits TEX_W bits
    pipe_d[ST_PREP].neg  = pipe_q[ST_IN].d[D_W-1];
    pipe_d[ST_PREP].v    = pipe_q[ST_IN].d[D_W-1] ? V_W'(-pipe_q[ST_IN].d) :
                                                     V_W'(pipe_q[ST_IN].d);
    pipe_d[ST_PREP].y_ok = (pipe_q[ST_IN].h > 0) && (pipe_q[ST_IN].s >= 0) &&
                           (pipe_q[ST_IN].s < $signed({pipe_q[ST_IN].h[HS_W-1],
                                                       pipe_q[ST_IN].h}));
    pipe_d[ST_PREP].h16  = pipe_q[ST_IN].h[SCR_W-1:0];
    pipe_d[ST_PREP].rem  = NUM_W'(th_q) * NUM_W'(pipe_q[ST_IN].s[SCR_W-1:0]);
    pipe_d[ST_PREP].quo  = '0;

    // column: coord mod tile, then scale to the texture width
    pipe_d[ST_RECIP_M].qm = mod_prod[2*V_W-1:V_W];
    pipe_d[ST_BACK_M].qt  = mod_back[V_W-1:0];
    // beyond the map edge the column is zero, and invalid when also off the tile grid
    pipe_d[ST_MOD].m      = pipe_q[ST_MOD-1].neg ? '0 : m_raw[MW-1:0];
    pipe_d[ST_MOD].bad    = pipe_q[ST_MOD-1].neg && (m_raw != '0);
    pipe_d[ST_SCALE].p    = PW'(pipe_q[ST_SCALE-1].m) * PW'(tw_q);
    pipe_d[ST_RECIP_X].qx = x_prod[2*PW-1:PW];
    pipe_d[ST_BACK_X].qxt = x_back[PW-1:0];
    pipe_d[ST_X].x        = pipe_q[ST_X-1].qx[TEX_W-1:0]
                          + TEX_W'(x_rem >= PW'(TILE_C));

    // row: restoring division, one quotient bit per stage, msb first
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = NUM_W'(pipe_q[DIV_FIRST+i-1].h16) << (DIV_STEPS - 1 - i);
      ge    = pipe_q[DIV_FIRST+i-1].rem >= trial;
      pipe_d[DIV_FIRST+i].rem = ge ? (pipe_q[DIV_FIRST+i-1].rem - trial) :
                                     pipe_q[DIV_FIRST+i-1].rem;
      pipe_d[DIV_FIRST+i].quo = {pipe_q[DIV_FIRST+i-1].quo[DIV_STEPS-2:0], ge};
    end

    // byte offset: x*bpp/8 + tw*y*bpp/8, each term floored
    pipe_d[ST_MUL_A].ty  = TY_W'(tw_q) * TY_W'(pipe_q[ST_Y].quo);
    pipe_d[ST_MUL_A].xb  = XB_W'(pipe_q[ST_Y].x) * XB_W'(bpp_q);
    pipe_d[ST_MUL_B].tyb = TYB_W'(pipe_q[ST_MUL_A].ty) * TYB_W'(bpp_q);

    pipe_d[ST_OUT].tex_ok = pipe_q[ST_MUL_B].y_ok && !pipe_q[ST_MUL_B].bad;
    pipe_d[ST_OUT].quo    = pipe_d[ST_OUT].tex_ok ? pipe_q[ST_MUL_B].quo : '0;
    pipe_d[ST_OUT].off    = pipe_d[ST_OUT].tex_ok ?
                            (OFF_W'(pipe_q[ST_MUL_B].xb[XB_W-1:3]) +
                             pipe_q[ST_MUL_B].tyb[OFF_W+2:3]) : '0;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // valid bits travel with the payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[ST_IN]) begin
        vld_q[ST_IN] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign out_valid_o      = vld_q[ST_OUT];
  assign texel_valid_o    = pipe_q[ST_OUT].tex_ok;
  assign texture_select_o = pipe_q[ST_OUT].face;
  assign texel_x_o        = pipe_q[ST_OUT].x;
  assign texel_y_o        = pipe_q[ST_OUT].quo;
  assign byte_offset_o    = pipe_q[ST_OUT].off;

  // request side is held off only when no stage has room
  `ASSERT_IMPLY(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, &vld_q,
                "request stalled while a pipeline stage is empty")
  // corrected remainder lies inside the tile
  `ASSERT_IMPLY(a_mod_in_tile, clk_i, rst_ni, vld_q[ST_MOD],
                TIW'(pipe_q[ST_MOD].m) < TILE_C,
                "tile remainder not below tile size")
  // off-grid hit beyond the map edge gives column zero
  `ASSERT_IMPLY(a_bad_column_zero, clk_i, rst_ni, vld_q[ST_X] && pipe_q[ST_X].bad,
                pipe_q[ST_X].x == '0, "off-grid hit with nonzero column")
  // in-range row leaves a remainder below the wall height
  `ASSERT_IMPLY(a_div_remainder, clk_i, rst_ni, vld_q[ST_Y] && pipe_q[ST_Y].y_ok,
                pipe_q[ST_Y].rem < NUM_W'(pipe_q[ST_Y].h16),
                "row divider remainder not below wall height")

endmodule
